FILE: design/tdi_pkg.sv
// Shared types, constants and table contents for the thermal derating block.
`timescale 1ns / 1ps
package tdi_pkg;

  localparam int TABLE_DEPTH        = 32;
  localparam int TEMP_FRACTION_BITS = 4;

  localparam int IDX_W  = $clog2(TABLE_DEPTH);
  localparam int FRAC_W = (TEMP_FRACTION_BITS == 0) ? 1 : TEMP_FRACTION_BITS;
  localparam int STEP   = 1 << TEMP_FRACTION_BITS;

  // frac (unsigned, one sign bit added) times a 9-bit signed entry difference
  localparam int PROD_W = FRAC_W + 10;

  localparam logic [FRAC_W-1:0] FRAC_MASK = FRAC_W'(STEP - 1);
  localparam logic signed [PROD_W-1:0] DIV_BIAS = PROD_W'(STEP - 1);

  localparam int TEMP_W = 12;
  localparam int DUTY_W = 8;
  localparam int EIDX_W = 5;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 12;

  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_DUTY = 1'b1;

  localparam logic [TEMP_W-1:0] THRESHOLD_RST    = 12'd1120;
  localparam logic [DUTY_W-1:0] DEFAULT_DUTY_RST = 8'd100;

  localparam logic [DUTY_W-1:0] FLAT_DUTY = 8'd100;
  localparam logic [DUTY_W-1:0] TAIL_DUTY = 8'd10;
  localparam logic [DUTY_W-1:0] SLOPE_DUTY [8] = '{
    8'd85, 8'd71, 8'd59, 8'd48, 8'd38, 8'd29, 8'd22, 8'd16
  };

  localparam logic action_tick  = 1'b0;
  localparam logic action_write = 1'b1;

  typedef enum logic [3:0] {
    MODE_INIT     = 4'b0001,
    MODE_BOOT     = 4'b0010,
    MODE_NORMAL   = 4'b0100,
    MODE_DERATING = 4'b1000
  } tdi_mode_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] lo_addr;
    logic [IDX_W-1:0] hi_addr;
  } tdi_rd_req_t;

  typedef struct packed {
    logic              en;
    logic [IDX_W-1:0]  addr;
    logic [DUTY_W-1:0] data;
  } tdi_wr_req_t;

  // Power-up contents: flat region, the knee, then the floor value.
  function automatic logic [DUTY_W-1:0] tdi_reset_entry(input logic [IDX_W-1:0] a);
    int        ai;
    logic [2:0] si;
    ai = 32'(a);
    si = 3'(ai - 16);
    if (ai < 16) begin
      return FLAT_DUTY;
    end else if (ai < 24) begin
      return SLOPE_DUTY[si];
    end
    return TAIL_DUTY;
  endfunction

endpackage

FILE: design/tdi_ram.sv
// Generic RAM: one write port, two registered read ports.
`timescale 1ns / 1ps
module tdi_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

FILE: design/tdi_table.sv
// Duty table: RAM plus per-entry valid bits that stand in for the power-up contents.
`timescale 1ns / 1ps
module tdi_table (
  input  logic                         clk,
  input  logic                         rst_n,
  input  tdi_pkg::tdi_wr_req_t         wr,
  input  tdi_pkg::tdi_rd_req_t         rd,
  output logic [tdi_pkg::DUTY_W-1:0]   lo_duty,
  output logic [tdi_pkg::DUTY_W-1:0]   hi_duty
);
  import tdi_pkg::*;

  logic [TABLE_DEPTH-1:0] valid_r;
  logic [TABLE_DEPTH-1:0] valid_nxt;
  logic                   lo_valid_r;
  logic                   hi_valid_r;
  logic [IDX_W-1:0]       lo_addr_r;
  logic [IDX_W-1:0]       hi_addr_r;
  logic [DUTY_W-1:0]      lo_ram;
  logic [DUTY_W-1:0]      hi_ram;

  tdi_ram #(
    .WIDTH (DUTY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk     (clk),
    .we      (wr.en),
    .waddr   (wr.addr),
    .wdata   (wr.data),
    .re      (rd.en),
    .raddr_a (rd.lo_addr),
    .raddr_b (rd.hi_addr),
    .rdata_a (lo_ram),
    .rdata_b (hi_ram)
  );

  always_comb begin
    valid_nxt = valid_r;
    if (wr.en) begin
      valid_nxt[wr.addr] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Capture validity and address alongside the registered RAM read.
  always_ff @(posedge clk) begin
    if (rd.en) begin
      lo_valid_r <= valid_r[rd.lo_addr];
      hi_valid_r <= valid_r[rd.hi_addr];
      lo_addr_r  <= rd.lo_addr;
      hi_addr_r  <= rd.hi_addr;
    end
  end

  assign lo_duty = lo_valid_r ? lo_ram : tdi_reset_entry(lo_addr_r);
  assign hi_duty = hi_valid_r ? hi_ram : tdi_reset_entry(hi_addr_r);

endmodule

FILE: design/tdi_interp.sv
// Linear interpolation between two neighboring table entries.
`timescale 1ns / 1ps
module tdi_interp (
  input  logic [tdi_pkg::DUTY_W-1:0] lo_duty,
  input  logic [tdi_pkg::DUTY_W-1:0] hi_duty,
  input  logic [tdi_pkg::FRAC_W-1:0] frac,
  input  logic                       top,
  output logic [tdi_pkg::DUTY_W-1:0] duty
);
  import tdi_pkg::*;

  logic signed [DUTY_W:0]   delta;
  logic signed [FRAC_W:0]   frac_s;
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] biased;
  logic signed [PROD_W-1:0] quot;

  always_comb begin
    delta  = $signed({1'b0, hi_duty}) - $signed({1'b0, lo_duty});
    frac_s = $signed({1'b0, frac});
    prod   = PROD_W'(frac_s) * PROD_W'(delta);
    // truncate toward zero: bias negative products before the shift
    biased = prod[PROD_W-1] ? (prod + DIV_BIAS) : prod;
    quot   = biased >>> TEMP_FRACTION_BITS;
    if (top) begin
      duty = lo_duty;
    end else begin
      duty = lo_duty + quot[DUTY_W-1:0];
    end
  end

endmodule

FILE: design/thermal_derating_duty_interpolator_core.sv
// Top level: input stage, table read stage, mode machine and result register.
// A tick moves from the input stage to the read stage, then to the result register.
// Throughput: one item per cycle unless the output stalls; the dual-read table RAM
// serves a tick each cycle. Writes produce no result and retire in the input stage.
// Reset clears the mode to init, the registers to their defaults and all
// table valid bits, so the table reads its power-up contents at once.
`timescale 1ns / 1ps
module thermal_derating_duty_interpolator_core (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_wr_en,
  input  logic [tdi_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tdi_pkg::CFG_DATA_W-1:0]   cfg_wr_data,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // [11:0] temperature, [16:12] entry_index, [24:17] entry_value, [31:25] zero
  input  logic [31:0]                      in_tdata,
  // [0] action
  input  logic                             in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [0] derating_active, [8:1] duty, [15:9] zero
  output logic [15:0]                      out_tdata
);
  import tdi_pkg::*;

  logic [TEMP_W-1:0] threshold_r;
  logic [DUTY_W-1:0] default_duty_r;

  logic              s1_v_r;
  logic              s1_write_r;
  logic [TEMP_W-1:0] s1_temp_r;
  logic [EIDX_W-1:0] s1_eidx_r;
  logic [DUTY_W-1:0] s1_eval_r;

  logic              s2_v_r;
  logic              s2_hot_r;
  logic              s2_top_r;
  logic [FRAC_W-1:0] s2_frac_r;

  tdi_mode_t         mode_r;
  tdi_mode_t         mode_nxt;

  logic              out_valid_r;
  logic              out_derating_r;
  logic [DUTY_W-1:0] out_duty_r;

  logic              out_free;
  logic              s2_free;
  logic              s2_adv;
  logic              s1_adv;
  logic              in_fire;

  logic signed [TEMP_W:0] diff;
  logic                   s1_hot;
  logic [TEMP_W-1:0]      diff_u;
  logic [TEMP_W-1:0]      idx_full;
  logic                   s1_top;
  logic [IDX_W-1:0]       idx;

  tdi_rd_req_t       rd;
  tdi_wr_req_t       wr;
  logic [DUTY_W-1:0] lo_duty;
  logic [DUTY_W-1:0] hi_duty;
  logic [DUTY_W-1:0] interp_duty;
  logic              use_interp;
  logic [DUTY_W-1:0] duty_nxt;

  // Handshake: the result register frees the pipe as soon as it is drained.
  assign out_free  = !out_valid_r || out_tready;
  assign s2_free   = !s2_v_r || out_free;
  assign s2_adv    = s2_v_r && out_free;
  assign s1_adv    = s1_v_r && (s1_write_r || s2_free);
  assign in_tready = !s1_v_r || s1_adv;
  assign in_fire   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r    <= THRESHOLD_RST;
      default_duty_r <= DEFAULT_DUTY_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_THRESHOLD:    threshold_r    <= cfg_wr_data;
        CFG_DEFAULT_DUTY: default_duty_r <= cfg_wr_data[DUTY_W-1:0];
        default: ;
      endcase
    end
  end

  // Input stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_tready) begin
      s1_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_write_r <= in_tuser;
      s1_temp_r  <= in_tdata[11:0];
      s1_eidx_r  <= in_tdata[16:12];
      s1_eval_r  <= in_tdata[24:17];
    end
  end

  // Offset above threshold, table index and fraction
  always_comb begin
    diff     = $signed({s1_temp_r[TEMP_W-1], s1_temp_r})
             - $signed({threshold_r[TEMP_W-1], threshold_r});
    s1_hot   = !diff[TEMP_W];
    diff_u   = diff[TEMP_W-1:0];
    idx_full = diff_u >> TEMP_FRACTION_BITS;
    s1_top   = 32'(idx_full) >= (TABLE_DEPTH - 1);
    idx      = idx_full[IDX_W-1:0];

    rd.en      = s1_adv && !s1_write_r;
    rd.lo_addr = s1_top ? IDX_W'(TABLE_DEPTH - 1) : idx;
    rd.hi_addr = s1_top ? IDX_W'(TABLE_DEPTH - 1) : (idx + IDX_W'(1));

    wr.en   = s1_adv && s1_write_r && (32'(s1_eidx_r) < TABLE_DEPTH);
    wr.addr = IDX_W'(s1_eidx_r);
    wr.data = s1_eval_r;
  end

  tdi_table u_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (wr),
    .rd      (rd),
    .lo_duty (lo_duty),
    .hi_duty (hi_duty)
  );

  // Read stage: ticks only, writes retire in the input stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (s2_free) begin
      s2_v_r <= s1_adv && !s1_write_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rd.en) begin
      s2_hot_r  <= s1_hot;
      s2_top_r  <= s1_top;
      s2_frac_r <= diff_u[FRAC_W-1:0] & FRAC_MASK;
    end
  end

  tdi_interp u_interp (
    .lo_duty (lo_duty),
    .hi_duty (hi_duty),
    .frac    (s2_frac_r),
    .top     (s2_top_r),
    .duty    (interp_duty)
  );

  always_comb begin
    use_interp = 1'b0;
    unique case (mode_r)
      MODE_INIT:     mode_nxt = MODE_NORMAL;
      MODE_BOOT:     mode_nxt = MODE_DERATING;
      MODE_NORMAL:   mode_nxt = s2_hot_r ? MODE_DERATING : MODE_NORMAL;
      MODE_DERATING: begin
        mode_nxt   = s2_hot_r ? MODE_DERATING : MODE_NORMAL;
        use_interp = s2_hot_r;
      end
      default:       mode_nxt = MODE_INIT;
    endcase
    duty_nxt = use_interp ? interp_duty : default_duty_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_INIT;
    end else if (s2_adv) begin
      mode_r <= mode_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_adv) begin
      out_derating_r <= (mode_nxt == MODE_DERATING);
      out_duty_r     <= duty_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_duty_r, out_derating_r};

  // The pending result always reports the mode it left behind.
  a_flag_matches_mode: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_derating_r == (mode_r == MODE_DERATING)))
    else $error("derating flag disagrees with mode");

  // A table write and a tick read never share a cycle.
  a_no_rd_wr_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(rd.en && wr.en))
    else $error("table read and write in the same cycle");

  // Leaving reset starts in init with no result pending.
  a_reset_state: assert property (@(posedge clk)
    (rst_n && $past(!rst_n)) |->
      (mode_r == MODE_INIT && !out_valid_r && !s1_v_r && !s2_v_r))
    else $error("reset state not clean");

endmodule

FILE: tb/sv/testbench.sv
// Self-checking testbench for the thermal derating duty interpolator core.
`timescale 1ns / 1ps
module testbench;
  import tdi_pkg::*;

  typedef struct packed {
    logic              active;
    logic [DUTY_W-1:0] duty;
  } duty_result_t;

  localparam int HOLD_OFF_CYCLES = 300;
  localparam int PRINT_CAP       = 30;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wr_data = '0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [31:0]           in_tdata = '0;
  logic                  in_tuser = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [15:0]           out_tdata;

  // Shadow of the block's state, updated on every transfer
  tdi_mode_t                thermal_mode;
  logic signed [TEMP_W-1:0] threshold_shadow;
  logic [DUTY_W-1:0]        default_duty_shadow;
  logic [DUTY_W-1:0]        duty_curve [TABLE_DEPTH];
  duty_result_t             pending_duty_q[$];
  int                       mismatch_count = 0;

  bit in_gaps = 1'b1;
  bit out_gaps = 1'b1;
  int hold_off_req = 0;
  int hold_off_seen = 0;
  int hold_off_left = 0;

  thermal_derating_duty_interpolator_core i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    #(10_000_000);
    $display("thermal_derating_duty_interpolator_core: mismatch");
    $finish;
  end

  // Step the mode machine for one tick and return the duty it reports.
  function automatic duty_result_t derate_tick(input logic signed [TEMP_W-1:0] temp);
    duty_result_t res;
    logic         hot;
    int           diff;
    int           seg;
    int           frac;
    int           lo;
    int           hi;
    hot      = (temp >= threshold_shadow);
    res.duty = default_duty_shadow;
    case (thermal_mode)
      MODE_INIT: thermal_mode = MODE_NORMAL;
      MODE_BOOT: thermal_mode = MODE_DERATING;
      MODE_NORMAL: thermal_mode = hot ? MODE_DERATING : MODE_NORMAL;
      default: begin
        thermal_mode = hot ? MODE_DERATING : MODE_NORMAL;
        if (hot) begin
          diff = int'(temp) - int'(threshold_shadow);
          seg  = diff / STEP;
          frac = diff - seg * STEP;
          if (seg >= TABLE_DEPTH - 1) begin
            res.duty = duty_curve[TABLE_DEPTH-1];
          end else begin
            lo       = int'(duty_curve[seg]);
            hi       = int'(duty_curve[seg+1]);
            // signed division truncates toward zero on a falling segment
            res.duty = DUTY_W'(lo + (frac * (hi - lo)) / STEP);
          end
        end
      end
    endcase
    res.active = (thermal_mode == MODE_DERATING);
    return res;
  endfunction

  // Track config writes and input transfers, then check each output transfer.
  always @(posedge clk) begin
    duty_result_t got;
    duty_result_t want;
    if (!rst_n) begin
      thermal_mode        = MODE_INIT;
      threshold_shadow    = 12'sd1120;
      default_duty_shadow = 8'd100;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        if (i < 16) duty_curve[i] = 8'd100;
        else if (i < 24) duty_curve[i] = SLOPE_DUTY[i-16];
        else duty_curve[i] = 8'd10;
      end
      pending_duty_q.delete();
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_THRESHOLD:    threshold_shadow = cfg_wr_data[TEMP_W-1:0];
          CFG_DEFAULT_DUTY: default_duty_shadow = cfg_wr_data[DUTY_W-1:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        if (in_tuser == action_write) duty_curve[in_tdata[16:12]] = in_tdata[24:17];
        else pending_duty_q.push_back(derate_tick(in_tdata[TEMP_W-1:0]));
      end
      if (out_tvalid && out_tready) begin
        got.active = out_tdata[0];
        got.duty   = out_tdata[8:1];
        if (pending_duty_q.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= PRINT_CAP)
            $display("%0t: unexpected result, expected none, actual active=%0b duty=%0d",
                     $time, got.active, got.duty);
        end else begin
          want = pending_duty_q.pop_front();
          if (got.active !== want.active) begin
            mismatch_count++;
            if (mismatch_count <= PRINT_CAP)
              $display("%0t: derating_active expected %0b actual %0b",
                       $time, want.active, got.active);
          end
          if (got.duty !== want.duty) begin
            mismatch_count++;
            if (mismatch_count <= PRINT_CAP)
              $display("%0t: duty expected %0d actual %0d", $time, want.duty, got.duty);
          end
        end
      end
    end
  end

  // Result side: random stalls, plus a long hold-off on request.
  always @(posedge clk) begin
    if (hold_off_left != 0) begin
      out_tready    <= 1'b0;
      hold_off_left <= hold_off_left - 1;
    end else if (hold_off_seen != hold_off_req) begin
      hold_off_seen <= hold_off_req;
      hold_off_left <= HOLD_OFF_CYCLES;
      out_tready    <= 1'b0;
    end else begin
      out_tready <= !out_gaps || ($urandom_range(99) >= 31);
    end
  end

  // Offer one item and hold it until the transfer.
  task automatic send_item(input logic act, input logic [TEMP_W-1:0] temp,
                           input logic [EIDX_W-1:0] eidx, input logic [DUTY_W-1:0] evalue);
    while (in_gaps && $urandom_range(99) < 31) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= {7'd0, evalue, eidx, temp};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic send_tick(input int temp);
    send_item(action_tick, TEMP_W'(temp), EIDX_W'($urandom), DUTY_W'($urandom));
  endtask

  task automatic send_entry(input int eidx, input int evalue);
    send_item(action_write, TEMP_W'($urandom), EIDX_W'(eidx), DUTY_W'(evalue));
  endtask

  // Drop valid and wait until every tick has returned and writes have retired.
  task automatic settle_pipeline();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_duty_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic load_settings(input int threshold, input int duty);
    settle_pipeline();
    cfg_wr_en   <= 1'b1;
    cfg_index   <= CFG_THRESHOLD;
    cfg_wr_data <= CFG_DATA_W'(threshold);
    @(posedge clk);
    cfg_index   <= CFG_DEFAULT_DUTY;
    cfg_wr_data <= {4'($urandom), DUTY_W'(duty)};
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic check_power_up_modes();
    send_tick(0);
    send_tick(1120);
    send_tick(1120);
    send_tick(1400);
    send_tick(2047);
    send_tick(1119);
    send_tick(-2048);
  endtask

  // Full-scale steps at both ends of the curve and the top entry.
  task automatic check_table_edges();
    send_entry(0, 0);
    send_entry(1, 255);
    send_entry(30, 255);
    send_entry(31, 0);
    send_tick(1120);
    send_tick(1135);
    send_tick(1615);
    send_tick(1616);
    send_tick(1600);
  endtask

  task automatic check_register_extremes();
    load_settings(-2048, 0);
    send_tick(-2048);
    send_tick(2047);
    load_settings(2047, 255);
    send_tick(2046);
    send_tick(2047);
    send_tick(2047);
  endtask

  // Stall the result side while ticks keep coming, so the input backs up.
  task automatic check_output_backpressure();
    load_settings(1120, 100);
    in_gaps = 1'b0;
    hold_off_req++;
    for (int k = 0; k < 40; k++) send_tick(1100 + int'($urandom_range(600)));
    in_gaps = 1'b1;
  endtask

  task automatic run_random_phase(input int threshold, input int duty, input int n_items);
    int pick;
    int t;
    load_settings(threshold, duty);
    for (int k = 0; k < n_items; k++) begin
      pick = $urandom_range(99);
      if (pick < 15) begin
        send_entry($urandom_range(TABLE_DEPTH - 1), $urandom_range(255));
      end else if (pick < 25) begin
        send_tick(int'($urandom_range(4095)) - 2048);
      end else begin
        // mostly just above the threshold so the curve gets exercised
        t = threshold + int'($urandom_range(560)) - 48;
        if (t > 2047) t = 2047;
        if (t < -2048) t = -2048;
        send_tick(t);
      end
    end
  endtask

  task automatic check_random_traffic();
    run_random_phase(int'($urandom_range(4095)) - 2048, $urandom_range(255), 150);
    in_gaps  = 1'b0;
    out_gaps = 1'b0;
    run_random_phase(1120, 100, 150);
    in_gaps  = 1'b1;
    out_gaps = 1'b1;
    run_random_phase(-2048, 0, 150);
    run_random_phase(2047, 255, 150);
    run_random_phase(int'($urandom_range(1700)) - 200, $urandom_range(255), 150);
    run_random_phase(int'($urandom_range(1700)) - 200, $urandom_range(255), 150);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    check_power_up_modes();
    check_table_edges();
    check_register_extremes();
    check_output_backpressure();
    check_random_traffic();
    settle_pipeline();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("thermal_derating_duty_interpolator_core: match");
    end else begin
      $display("thermal_derating_duty_interpolator_core: mismatch");
    end
    $finish;
  end

endmodule
